// ===== rtl/core/pttr_pkg.sv =====
// shared constants and types for the permutation to transpositions block
`default_nettype none
package pttr_pkg;

    localparam int MAX_SIZE_DEF = 64;
    localparam int VAL_W        = 6;
    localparam int KIND_W       = 2;
    // largest number of distinct element values, so the largest valid permutation
    localparam int VAL_SPAN     = 1 << VAL_W;

    localparam logic [KIND_W-1:0] KIND_PAIR    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;

    // hand-off from the loader to the cycle walker
    typedef struct packed {
        logic go;
        logic bad;
    } t_run;

endpackage
`default_nettype wire

// ===== rtl/core/pttr_if.sv =====
// valid/ready channels for the element input and the transposition output
`default_nettype none
interface pttr_in_if;
    import pttr_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] element_value;
    logic             is_last;
    modport source (output valid, element_value, is_last, input ready);
    modport sink (input valid, element_value, is_last, output ready);
endinterface

interface pttr_out_if;
    import pttr_pkg::*;
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  first_index;
    logic [VAL_W-1:0]  second_index;
    logic [KIND_W-1:0] kind;
    logic              last;
    modport source (output valid, first_index, second_index, kind, last, input ready);
    modport sink (input valid, first_index, second_index, kind, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pttr_store.sv =====
// permutation store: one write port, one registered read port
`default_nettype none
module pttr_store #(
    parameter int MAX_SIZE = pttr_pkg::MAX_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(MAX_SIZE)-1:0]   i_waddr,
    input  wire logic [pttr_pkg::VAL_W-1:0]    i_wdata,
    input  wire logic                          i_re,
    input  wire logic [$clog2(MAX_SIZE)-1:0]   i_raddr,
    output logic      [pttr_pkg::VAL_W-1:0]    o_rdata
);
    import pttr_pkg::*;

    logic [VAL_W-1:0] r_mem [MAX_SIZE];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/pttr_load.sv =====
// element loader: count, duplicate marks, running maximum, validity
`default_nettype none
module pttr_load #(
    parameter int MAX_SIZE = pttr_pkg::MAX_SIZE_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic [pttr_pkg::VAL_W-1:0]         i_value,
    input  wire logic                               i_is_last,
    input  wire logic                               i_busy,
    output logic                                    o_ready,
    output logic                                    o_we,
    output logic      [$clog2(MAX_SIZE)-1:0]        o_waddr,
    output logic      [pttr_pkg::VAL_W-1:0]         o_wdata,
    output pttr_pkg::t_run                          o_run,
    output logic      [$clog2(MAX_SIZE+2)-1:0]      o_n
);
    import pttr_pkg::*;

    localparam int CW = $clog2(MAX_SIZE + 2);
    localparam int AW = $clog2(MAX_SIZE);
    localparam int VN = (MAX_SIZE < VAL_SPAN) ? MAX_SIZE : VAL_SPAN;
    localparam int SW = (VN > 1) ? $clog2(VN) : 1;

    logic [VN-1:0] r_seen, n_seen;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_max, n_max;
    logic          r_bad, n_bad;
    logic          r_go;
    logic          r_run_bad;
    logic [CW-1:0] r_n;

    logic          acc;
    logic          v_ok;
    logic          full;
    logic          dup;
    logic          fin_bad;

    assign o_ready = !i_busy && !r_go;
    assign acc     = i_valid && o_ready;
    assign v_ok    = (32'(i_value) < MAX_SIZE);
    assign full    = (r_cnt >= CW'(MAX_SIZE));
    assign dup     = v_ok && r_seen[SW'(i_value)];

    always_comb begin
        n_seen = r_seen;
        n_max  = r_max;
        n_cnt  = full ? r_cnt : r_cnt + CW'(1);
        n_bad  = r_bad || full || !v_ok || dup;
        if (!full && v_ok) begin
            n_seen[SW'(i_value)] = 1'b1;
            if (CW'(i_value) > r_max) begin
                n_max = CW'(i_value);
            end
        end
    end

    // a value at or above the final count means it is no permutation of 0..n-1
    assign fin_bad = n_bad || (n_max >= n_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_cnt  <= '0;
            r_max  <= '0;
            r_bad  <= 1'b0;
            r_go   <= 1'b0;
        end else begin
            r_go <= acc && i_is_last;
            if (acc) begin
                if (i_is_last) begin
                    r_seen <= '0;
                    r_cnt  <= '0;
                    r_max  <= '0;
                    r_bad  <= 1'b0;
                end else begin
                    r_seen <= n_seen;
                    r_cnt  <= n_cnt;
                    r_max  <= n_max;
                    r_bad  <= n_bad;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_is_last) begin
            r_run_bad <= fin_bad;
            r_n       <= n_cnt;
        end
    end

    assign o_we      = acc && !full && v_ok;
    assign o_waddr   = AW'(r_cnt);
    assign o_wdata   = i_value;
    assign o_run.go  = r_go;
    assign o_run.bad = r_run_bad;
    assign o_n       = r_n;

endmodule
`default_nettype wire

// ===== rtl/core/pttr_walk.sv =====
// cycle walker: visited marks, store reads, pending pair and output register
`default_nettype none
module pttr_walk #(
    parameter int MAX_SIZE = pttr_pkg::MAX_SIZE_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pttr_pkg::t_run                     i_run,
    input  wire logic [$clog2(MAX_SIZE+2)-1:0]      i_n,
    output logic                                    o_busy,
    output logic                                    o_re,
    output logic      [$clog2(MAX_SIZE)-1:0]        o_raddr,
    input  wire logic [pttr_pkg::VAL_W-1:0]         i_rdata,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic      [pttr_pkg::VAL_W-1:0]         o_first,
    output logic      [pttr_pkg::VAL_W-1:0]         o_second,
    output logic      [pttr_pkg::KIND_W-1:0]        o_kind,
    output logic                                    o_last
);
    import pttr_pkg::*;

    localparam int CW = $clog2(MAX_SIZE + 2);
    localparam int AW = $clog2(MAX_SIZE);
    localparam int VN = (MAX_SIZE < VAL_SPAN) ? MAX_SIZE : VAL_SPAN;
    localparam int VW = (VN > 1) ? $clog2(VN) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FOLLOW = 2'd2;
    localparam logic [1:0] ST_END    = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_n;
    logic              r_bad;
    logic [VN-1:0]     r_vis, n_vis;
    logic              r_pv, n_pv;
    logic [VAL_W-1:0]  r_pi, n_pi;
    logic [VAL_W-1:0]  r_pj, n_pj;
    logic              r_ov, n_ov;
    logic [VAL_W-1:0]  r_of, n_of;
    logic [VAL_W-1:0]  r_os, n_os;
    logic [KIND_W-1:0] r_ok, n_ok;
    logic              r_ol, n_ol;

    logic              out_free;

    assign out_free = !r_ov || i_ready;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_vis   = r_vis;
        n_pv    = r_pv;
        n_pi    = r_pi;
        n_pj    = r_pj;
        n_ov    = r_ov && !i_ready;
        n_of    = r_of;
        n_os    = r_os;
        n_ok    = r_ok;
        n_ol    = r_ol;
        o_re    = 1'b0;
        o_raddr = AW'(r_i);
        case (r_state)
            ST_IDLE: begin
                if (i_run.go) begin
                    n_i     = '0;
                    n_state = i_run.bad ? ST_END : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_i == r_n) begin
                    n_state = ST_END;
                end else if (r_vis[VW'(r_i)]) begin
                    n_i = r_i + CW'(1);
                end else begin
                    // open a new cycle at its smallest index
                    n_vis[VW'(r_i)] = 1'b1;
                    o_re            = 1'b1;
                    n_state         = ST_FOLLOW;
                end
            end
            ST_FOLLOW: begin
                if (i_rdata == VAL_W'(r_i)) begin
                    n_i     = r_i + CW'(1);
                    n_state = ST_SCAN;
                end else if (!r_pv || out_free) begin
                    // older pending pair is not the final one
                    if (r_pv) begin
                        n_ov = 1'b1;
                        n_of = r_pi;
                        n_os = r_pj;
                        n_ok = KIND_PAIR;
                        n_ol = 1'b0;
                    end
                    n_vis[VW'(i_rdata)] = 1'b1;
                    n_pv    = 1'b1;
                    n_pi    = VAL_W'(r_i);
                    n_pj    = i_rdata;
                    o_re    = 1'b1;
                    o_raddr = AW'(i_rdata);
                end
            end
            ST_END: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ol = 1'b1;
                    if (r_bad) begin
                        n_of = '0;
                        n_os = '0;
                        n_ok = KIND_INVALID;
                    end else if (r_pv) begin
                        n_of = r_pi;
                        n_os = r_pj;
                        n_ok = KIND_PAIR;
                    end else begin
                        n_of = '0;
                        n_os = '0;
                        n_ok = KIND_NONE;
                    end
                    n_pv    = 1'b0;
                    n_vis   = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vis   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vis   <= n_vis;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i  <= n_i;
        r_pi <= n_pi;
        r_pj <= n_pj;
        r_of <= n_of;
        r_os <= n_os;
        r_ok <= n_ok;
        r_ol <= n_ol;
        if (r_state == ST_IDLE && i_run.go) begin
            r_n   <= i_n;
            r_bad <= i_run.bad;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_ov;
    assign o_first  = r_of;
    assign o_second = r_os;
    assign o_kind   = r_ok;
    assign o_last   = r_ol;

endmodule
`default_nettype wire

// ===== rtl/core/permutation_to_transpositions.sv =====
// Takes a permutation of 0..n-1 one element per item (is_last on the final one) and
// returns the transpositions (cycle start, k-th cycle element) that compose it, cycles
// taken in order of their smallest index; an identity gives one item of kind none, a
// repeated value, a value not below n or more than MAX_SIZE elements gives one item of
// kind invalid, and the final result of each permutation carries last. Elements are
// accepted one per cycle while no walk is pending. After the final element no item is
// accepted until the walk is done: it scans the indices in order and reads each cycle
// element from the permutation store through its single read port, and it also waits
// on any stall on the output side.
`default_nettype none
module permutation_to_transpositions #(
    parameter int MAX_SIZE = pttr_pkg::MAX_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pttr_in_if.sink          i_in,
    pttr_out_if.source       o_out
);
    import pttr_pkg::*;

    localparam int CW = $clog2(MAX_SIZE + 2);
    localparam int AW = $clog2(MAX_SIZE);

    logic             walk_busy;
    logic             st_we;
    logic [AW-1:0]    st_waddr;
    logic [VAL_W-1:0] st_wdata;
    logic             st_re;
    logic [AW-1:0]    st_raddr;
    logic [VAL_W-1:0] st_rdata;
    t_run             run;
    logic [CW-1:0]    run_n;

    pttr_load #(.MAX_SIZE(MAX_SIZE)) u_load (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_value   (i_in.element_value),
        .i_is_last (i_in.is_last),
        .i_busy    (walk_busy),
        .o_ready   (i_in.ready),
        .o_we      (st_we),
        .o_waddr   (st_waddr),
        .o_wdata   (st_wdata),
        .o_run     (run),
        .o_n       (run_n)
    );

    pttr_store #(.MAX_SIZE(MAX_SIZE)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    pttr_walk #(.MAX_SIZE(MAX_SIZE)) u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_run    (run),
        .i_n      (run_n),
        .o_busy   (walk_busy),
        .o_re     (st_re),
        .o_raddr  (st_raddr),
        .i_rdata  (st_rdata),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_first  (o_out.first_index),
        .o_second (o_out.second_index),
        .o_kind   (o_out.kind),
        .o_last   (o_out.last)
    );

`ifndef SYNTHESIS
    // no element is taken while the cycle walk runs
    a_no_load_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && walk_busy))
        else $error("input accepted during cycle walk");

    // the final element closes loading until its walk is done
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.is_last) |=> !i_in.ready)
        else $error("input ready right after final element");

    // identity and invalid reports stand alone
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != KIND_PAIR) |-> o_out.last)
        else $error("non-pair result without last");

    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != KIND_PAIR)
            |-> (o_out.first_index == '0 && o_out.second_index == '0))
        else $error("non-pair result with nonzero indices");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for permutation_to_transpositions: directed table plus random permutations
`timescale 1ns / 100ps
module tb;
    import pttr_pkg::*;

    localparam int SIZE         = MAX_SIZE_DEF;
    localparam int MAX_PAIRS    = 63;
    localparam int DIR_ROWS     = 18;
    localparam int RAND_ITEMS   = 332;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * SIZE + 8;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic              is_last;
        logic              typed;
        logic [KIND_W-1:0] kind;
    } t_elem_item;

    typedef struct packed {
        logic [VAL_W-1:0]  first_index;
        logic [VAL_W-1:0]  second_index;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_xpose;

    typedef enum int {
        SH_SHUFFLE, SH_RING, SH_IDENT, SH_REPEAT, SH_OUTSIDE, SH_NOISE, SH_OVERSIZE
    } t_shape;

    logic i_clk;
    logic i_rst_n;

    pttr_in_if  in_ch ();
    pttr_out_if out_ch ();

    permutation_to_transpositions uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // value, last, typed result, kind of the typed result
    t_elem_item dir_tab [DIR_ROWS] = '{
        '{6'd0,  1'b1, 1'b1, KIND_NONE},
        '{6'd63, 1'b1, 1'b1, KIND_INVALID},
        '{6'd1,  1'b0, 1'b0, KIND_PAIR},
        '{6'd0,  1'b1, 1'b0, KIND_PAIR},
        '{6'd0,  1'b0, 1'b0, KIND_PAIR},
        '{6'd0,  1'b1, 1'b1, KIND_INVALID},
        '{6'd2,  1'b0, 1'b0, KIND_PAIR},
        '{6'd0,  1'b1, 1'b1, KIND_INVALID},
        '{6'd0,  1'b0, 1'b0, KIND_PAIR},
        '{6'd1,  1'b0, 1'b0, KIND_PAIR},
        '{6'd2,  1'b1, 1'b1, KIND_NONE},
        '{6'd1,  1'b0, 1'b0, KIND_PAIR},
        '{6'd2,  1'b0, 1'b0, KIND_PAIR},
        '{6'd0,  1'b1, 1'b0, KIND_PAIR},
        '{6'd3,  1'b0, 1'b0, KIND_PAIR},
        '{6'd2,  1'b0, 1'b0, KIND_PAIR},
        '{6'd1,  1'b0, 1'b0, KIND_PAIR},
        '{6'd0,  1'b1, 1'b0, KIND_PAIR}
    };

    t_elem_item stim_q [$];
    t_xpose     new_pairs [$];
    t_xpose     due_pairs [$];
    int         taken  = 0;
    int         errors = 0;

    // predictor state
    logic [VAL_W-1:0] perm_mem [SIZE];
    bit               seen_mark [SIZE];
    bit               visit_mark [SIZE];
    int               elem_cnt = 0;
    bit               run_bad  = 1'b0;

    function automatic t_xpose mk_result(int a, int b, logic [KIND_W-1:0] k, logic l);
        t_xpose r;
        r.first_index  = VAL_W'(a);
        r.second_index = VAL_W'(b);
        r.kind         = k;
        r.last         = l;
        return r;
    endfunction

    function automatic void predict_element(logic [VAL_W-1:0] v, logic fin);
        int n, i, j, guard, cnt;
        t_xpose r;
        new_pairs.delete();
        if (elem_cnt >= SIZE) begin
            run_bad  = 1'b1;
            elem_cnt = SIZE + 1;
        end else begin
            if (int'(v) >= SIZE) begin
                run_bad = 1'b1;
            end else begin
                if (seen_mark[v]) run_bad = 1'b1;
                seen_mark[v]       = 1'b1;
                perm_mem[elem_cnt] = v;
            end
            elem_cnt++;
        end
        if (!fin) return;

        n = elem_cnt;
        for (i = 0; i < n && !run_bad; i++) begin
            if (int'(perm_mem[i]) >= n) run_bad = 1'b1;
        end

        if (run_bad) begin
            new_pairs.insert(new_pairs.size(), mk_result(0, 0, KIND_INVALID, 1'b1));
        end else begin
            cnt = 0;
            for (i = 0; i < n; i++) begin
                if (!visit_mark[i]) begin
                    visit_mark[i] = 1'b1;
                    j     = perm_mem[i];
                    guard = 0;
                    while (j != i && j < n && guard < n && cnt < MAX_PAIRS) begin
                        visit_mark[j] = 1'b1;
                        new_pairs.insert(new_pairs.size(), mk_result(i, j, KIND_PAIR, 1'b0));
                        cnt++;
                        j = perm_mem[j];
                        guard++;
                    end
                end
            end
            if (cnt == 0) begin
                new_pairs.insert(new_pairs.size(), mk_result(0, 0, KIND_NONE, 1'b1));
            end else begin
                r      = new_pairs.pop_back();
                r.last = 1'b1;
                new_pairs.insert(new_pairs.size(), r);
            end
        end
        visit_mark = '{default: 1'b0};
        seen_mark  = '{default: 1'b0};
        elem_cnt   = 0;
        run_bad    = 1'b0;
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic gen_random_part();
        int n, a, b, t, seq, pick, i;
        int perm [$];
        int ord [$];
        t_shape shape;
        t_elem_item e;
        seq = 0;
        while (stim_q.size() < DIR_ROWS + RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24)
                                            : $urandom_range(1, 10);
            // largest cases first so they always show up
            if (seq == 0) begin
                shape = SH_SHUFFLE;
                n     = SIZE;
            end else if (seq == 1) begin
                shape = SH_RING;
                n     = SIZE;
            end else if (seq == 2) begin
                shape = SH_OVERSIZE;
                n     = SIZE;
            end else if (pick < 40) begin
                shape = SH_SHUFFLE;
            end else if (pick < 60) begin
                shape = SH_RING;
            end else if (pick < 68) begin
                shape = SH_IDENT;
            end else if (pick < 80) begin
                shape = SH_REPEAT;
            end else if (pick < 90) begin
                shape = SH_OUTSIDE;
            end else begin
                shape = SH_NOISE;
            end
            if (shape == SH_REPEAT && n < 2) n = 2;

            perm.delete();
            for (i = 0; i < n; i++) perm.insert(perm.size(), i);
            if (shape != SH_IDENT) begin
                for (i = n - 1; i > 0; i--) begin
                    a       = $urandom_range(0, i);
                    t       = perm[i];
                    perm[i] = perm[a];
                    perm[a] = t;
                end
            end
            case (shape)
                SH_RING: begin
                    // shuffled order becomes one single cycle
                    ord = perm;
                    for (i = 0; i < n; i++) perm[ord[i]] = ord[(i + 1) % n];
                end
                SH_REPEAT: begin
                    a       = $urandom_range(0, n - 1);
                    b       = (a + 1 + $urandom_range(0, n - 2)) % n;
                    perm[a] = perm[b];
                end
                SH_OUTSIDE: begin
                    perm[$urandom_range(0, n - 1)] = $urandom_range(n, VAL_SPAN - 1);
                end
                SH_NOISE: begin
                    for (i = 0; i < n; i++) perm[i] = $urandom_range(0, VAL_SPAN - 1);
                end
                SH_OVERSIZE: begin
                    repeat ($urandom_range(1, 4)) begin
                        perm.insert(perm.size(), $urandom_range(0, VAL_SPAN - 1));
                    end
                end
                default: begin
                end
            endcase
            for (i = 0; i < perm.size(); i++) begin
                e.value   = VAL_W'(perm[i]);
                e.is_last = (i == perm.size() - 1);
                e.typed   = 1'b0;
                e.kind    = KIND_PAIR;
                stim_q.insert(stim_q.size(), e);
            end
            seq++;
        end
    endtask

    // item and result monitors, sampled at the rising edge
    always @(posedge i_clk) begin : monitor
        t_xpose exp_r;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_element(in_ch.element_value, in_ch.is_last);
                if (stim_q[taken].typed) begin
                    due_pairs.insert(due_pairs.size(),
                                     mk_result(0, 0, stim_q[taken].kind, 1'b1));
                end else begin
                    foreach (new_pairs[k]) due_pairs.insert(due_pairs.size(), new_pairs[k]);
                end
                taken++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (due_pairs.size() == 0) begin
                    $error("result with nothing expected: %s %0d %s %0d %s %0d %s %0d",
                           "first_index", out_ch.first_index,
                           "second_index", out_ch.second_index,
                           "kind", out_ch.kind, "last", out_ch.last);
                    errors++;
                end else begin
                    exp_r = due_pairs.pop_front();
                    check_field("first_index", exp_r.first_index, out_ch.first_index);
                    check_field("second_index", exp_r.second_index, out_ch.second_index);
                    check_field("kind", exp_r.kind, out_ch.kind);
                    check_field("last", exp_r.last, out_ch.last);
                end
            end
        end
    end

    // watchdog on cycles with no item and no result moving
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall patterns, one long hold-off mid run
    initial begin : rx_side
        logic [15:0] pat;
        int unsigned phase, mode;
        bit held;
        out_ch.ready = 1'b0;
        held  = 1'b0;
        phase = 0;
        mode  = 0;
        pat   = '1;
        forever begin
            @(negedge i_clk);
            if (!held && taken >= DIR_ROWS + 30) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (phase == 0) begin
                mode  = $urandom_range(0, 2);
                pat   = $urandom;
                phase = $urandom_range(16, 64);
            end
            phase--;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= pat[phase % 16];
                default: out_ch.ready <= pat[phase % 16] | pat[(phase + 5) % 16];
            endcase
        end
    end

    initial begin : main
        int idx, burst, gap;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.element_value = '0;
        in_ch.is_last       = 1'b0;

        foreach (dir_tab[r]) stim_q.insert(stim_q.size(), dir_tab[r]);
        gen_random_part();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idx   = 0;
        burst = $urandom_range(1, 20);
        gap   = 0;
        @(negedge i_clk);
        while (idx < stim_q.size()) begin
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                gap--;
                @(negedge i_clk);
            end else begin
                in_ch.valid         <= 1'b1;
                in_ch.element_value <= stim_q[idx].value;
                in_ch.is_last       <= stim_q[idx].is_last;
                @(posedge i_clk);
                while (!in_ch.ready) @(posedge i_clk);
                idx++;
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 20);
                    gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                @(negedge i_clk);
            end
        end
        in_ch.valid <= 1'b0;

        while (due_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pttr_pkg.sv
rtl/core/pttr_if.sv
rtl/core/pttr_store.sv
rtl/core/pttr_load.sv
rtl/core/pttr_walk.sv
rtl/core/permutation_to_transpositions.sv
tb/sv/tb.sv
